[rtl/hrft_pkg.sv]
// ============================================================================
// hrft_pkg - shared types and constants for the HTTP request field tagger
// Character codes, URL phase encoding, status codes and the result word.
// ============================================================================
package hrft_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned MATCH_W  = 2;

    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

    // progress through CR LF CR LF
    localparam logic [MATCH_W-1:0] M_NONE  = 2'd0;
    localparam logic [MATCH_W-1:0] M_CR    = 2'd1;
    localparam logic [MATCH_W-1:0] M_CRLF  = 2'd2;
    localparam logic [MATCH_W-1:0] M_CRLFC = 2'd3;

    // URL phase, one-hot
    typedef enum logic [5:0] {
        PH_SEEK   = 6'b000001,
        PH_SLASH1 = 6'b000010,
        PH_HOST   = 6'b000100,
        PH_PORT   = 6'b001000,
        PH_PATH   = 6'b010000,
        PH_DONE   = 6'b100000
    } t_url_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_END     = 3'd1,
        ST_NO_SPACE   = 3'd2,
        ST_NO_SLASHES = 3'd3,
        ST_HOST_OPEN  = 3'd4,
        ST_PORT_OPEN  = 3'd5
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              is_method;
        logic              is_host;
        logic              is_port;
        logic              is_path;
        logic              is_header;
        logic              done_res;
        t_status           status;
        logic              port80_implied;
    } t_result;

endpackage

[rtl/http_request_field_tagger.sv]
// ============================================================================
// http_request_field_tagger - tags each byte of a proxy request by field
// Path: an accepted byte waits in the input register, then moves to the result
// register, where its result becomes valid; a full result register holds it back.
// Throughput: one byte per cycle while the consumer takes results without stalling.
// Reset: synchronous, active low; clears both valid flags and all parse state.
// Parse state also returns to reset after the byte marked last.
// ============================================================================
module http_request_field_tagger (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hrft_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_last_byte,
    // output channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hrft_pkg::BYTE_W-1:0] o_byte_out,
    output logic                        o_is_method,
    output logic                        o_is_host,
    output logic                        o_is_port,
    output logic                        o_is_path,
    output logic                        o_is_header,
    output logic                        o_done_res,
    output logic [hrft_pkg::STATUS_W-1:0] o_status,
    output logic                        o_port80_implied
);

    // Input register: captures one word per accept. It drains into the
    // result register whenever that register is empty or being read, so
    // words stream back to back while results are taken, and one more word
    // is held here while a finished result waits.
    logic                        r_in_valid;
    logic [hrft_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_in_last;

    logic              out_free;   // result register can take a word
    logic              fire;       // word moves input reg -> result reg
    hrft_pkg::t_result tag_result;
    hrft_pkg::t_result out_result;

    assign fire    = r_in_valid & out_free;
    assign o_ready = ~r_in_valid | out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Tag logic; parse state advances only on fire, so stalls hold it.
    hrft_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_result    (tag_result)
    );

    hrft_result_reg u_result_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_in_valid),
        .i_result (tag_result),
        .i_ready  (i_ready),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_byte_out       = out_result.byte_out;
    assign o_is_method      = out_result.is_method;
    assign o_is_host        = out_result.is_host;
    assign o_is_port        = out_result.is_port;
    assign o_is_path        = out_result.is_path;
    assign o_is_header      = out_result.is_header;
    assign o_done_res       = out_result.done_res;
    assign o_status         = out_result.status;
    assign o_port80_implied = out_result.port80_implied;

endmodule

[rtl/hrft_classify.sv]
// ============================================================================
// hrft_classify - per-byte tag logic and request tracking state
// Tags the byte held in the input register and advances state when it moves on.
// ============================================================================
module hrft_classify (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [hrft_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_last_byte,
    output hrft_pkg::t_result             o_result
);

    logic                          r_method_closed, n_method_closed;
    hrft_pkg::t_url_phase          r_url_phase, n_url_phase;
    logic [hrft_pkg::MATCH_W-1:0]  r_match, n_match;
    logic                          r_end_found, n_end_found;
    logic                          r_prev_cr, n_prev_cr;
    logic                          r_hdr_started, n_hdr_started;
    logic                          r_port_dflt, n_port_dflt;

    logic is_cr, is_lf, is_sp, is_slash, is_colon;
    logic t_host, t_port, t_path;
    hrft_pkg::t_status status;

    assign is_cr    = (i_data_byte == hrft_pkg::CH_CR);
    assign is_lf    = (i_data_byte == hrft_pkg::CH_LF);
    assign is_sp    = (i_data_byte == hrft_pkg::CH_SP);
    assign is_slash = (i_data_byte == hrft_pkg::CH_SLASH);
    assign is_colon = (i_data_byte == hrft_pkg::CH_COLON);

    always_comb begin
        n_method_closed = r_method_closed | is_sp;
        n_hdr_started   = r_hdr_started | (is_lf & r_prev_cr);
        n_prev_cr       = is_cr;
        n_end_found     = r_end_found;
        n_port_dflt     = r_port_dflt;
        n_url_phase     = r_url_phase;
        t_host          = 1'b0;
        t_port          = 1'b0;
        t_path          = 1'b0;

        if (is_cr) begin
            n_match = (r_match == hrft_pkg::M_CRLF) ? hrft_pkg::M_CRLFC : hrft_pkg::M_CR;
        end else if (is_lf) begin
            if (r_match == hrft_pkg::M_CR) begin
                n_match = hrft_pkg::M_CRLF;
            end else begin
                if (r_match == hrft_pkg::M_CRLFC) n_end_found = 1'b1;
                n_match = hrft_pkg::M_NONE;
            end
        end else begin
            n_match = hrft_pkg::M_NONE;
        end

        case (r_url_phase)
            hrft_pkg::PH_SEEK: begin
                if (is_slash) n_url_phase = hrft_pkg::PH_SLASH1;
            end
            hrft_pkg::PH_SLASH1: begin
                n_url_phase = is_slash ? hrft_pkg::PH_HOST : hrft_pkg::PH_SEEK;
            end
            hrft_pkg::PH_HOST: begin
                if (is_slash) begin
                    n_port_dflt = 1'b1;
                    n_url_phase = hrft_pkg::PH_PATH;
                    t_path      = 1'b1;
                end else if (is_colon) begin
                    n_url_phase = hrft_pkg::PH_PORT;
                end else begin
                    t_host = 1'b1;
                end
            end
            hrft_pkg::PH_PORT: begin
                if (is_slash) begin
                    n_url_phase = hrft_pkg::PH_PATH;
                    t_path      = 1'b1;
                end else begin
                    t_port = 1'b1;
                end
            end
            hrft_pkg::PH_PATH: begin
                if (is_sp) n_url_phase = hrft_pkg::PH_DONE;
                else       t_path      = 1'b1;
            end
            default: begin
            end
        endcase

        // first failing check wins; judged on the state after this byte
        if (!n_end_found)                      status = hrft_pkg::ST_NO_END;
        else if (!n_method_closed)             status = hrft_pkg::ST_NO_SPACE;
        else if (n_url_phase == hrft_pkg::PH_SEEK ||
                 n_url_phase == hrft_pkg::PH_SLASH1) status = hrft_pkg::ST_NO_SLASHES;
        else if (n_url_phase == hrft_pkg::PH_HOST) status = hrft_pkg::ST_HOST_OPEN;
        else if (n_url_phase == hrft_pkg::PH_PORT) status = hrft_pkg::ST_PORT_OPEN;
        else                                   status = hrft_pkg::ST_OK;
    end

    always_comb begin
        o_result.byte_out       = i_data_byte;
        o_result.is_method      = ~r_method_closed & ~is_sp;
        o_result.is_host        = t_host;
        o_result.is_port        = t_port;
        o_result.is_path        = t_path;
        o_result.is_header      = r_hdr_started;
        o_result.done_res       = i_last_byte;
        o_result.status         = i_last_byte ? status : hrft_pkg::ST_OK;
        o_result.port80_implied = i_last_byte & n_port_dflt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last_byte)) begin
            r_method_closed <= 1'b0;
            r_url_phase     <= hrft_pkg::PH_SEEK;
            r_match         <= hrft_pkg::M_NONE;
            r_end_found     <= 1'b0;
            r_prev_cr       <= 1'b0;
            r_hdr_started   <= 1'b0;
            r_port_dflt     <= 1'b0;
        end else if (i_fire) begin
            r_method_closed <= n_method_closed;
            r_url_phase     <= n_url_phase;
            r_match         <= n_match;
            r_end_found     <= n_end_found;
            r_prev_cr       <= n_prev_cr;
            r_hdr_started   <= n_hdr_started;
            r_port_dflt     <= n_port_dflt;
        end
    end

endmodule

[rtl/hrft_result_reg.sv]
// ============================================================================
// hrft_result_reg - result register on the output channel
// Holds one tagged word until the consumer takes it.
// ============================================================================
module hrft_result_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hrft_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output hrft_pkg::t_result o_result
);

    logic              r_valid;
    hrft_pkg::t_result r_result;

    assign o_free   = ~r_valid | i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[rtl/hrft_checker.sv]
// ============================================================================
// hrft_checker - port-level assertions for the field tagger
// Checks status fields, tag consistency and output hold under stall.
// ============================================================================
module hrft_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [hrft_pkg::BYTE_W-1:0]   o_byte_out,
    input logic                          o_is_method,
    input logic                          o_is_host,
    input logic                          o_is_port,
    input logic                          o_is_path,
    input logic                          o_done_res,
    input logic [hrft_pkg::STATUS_W-1:0] o_status,
    input logic                          o_port80_implied
);

    // status and port 80 flag only show on the last word
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> o_status == hrft_pkg::ST_OK && !o_port80_implied)
        else $error("status fields set on a word that is not last");

    // at most one URL tag per byte
    a_url_tag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_is_host, o_is_port, o_is_path}) <= 1)
        else $error("more than one URL tag on a byte");

    // a space never belongs to the method
    a_space_untagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_out == hrft_pkg::CH_SP |-> !o_is_method)
        else $error("space tagged as method");

    // stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_byte_out) && $stable(o_status))
        else $error("output word changed while stalled");

endmodule

bind http_request_field_tagger hrft_checker u_hrft_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_byte_out       (o_byte_out),
    .o_is_method      (o_is_method),
    .o_is_host        (o_is_host),
    .o_is_port        (o_is_port),
    .o_is_path        (o_is_path),
    .o_done_res       (o_done_res),
    .o_status         (o_status),
    .o_port80_implied (o_port80_implied)
);

[bench/http_request_field_tagger_tb.sv]
// ============================================================================
// http_request_field_tagger_tb - self-checking bench for the request tagger
// Sends proxy request bytes (clean requests, broken ones and noise) through
// both valid/ready channels under random idling. A scoreboard predicts each
// result word from its own model of the parser and checks it on arrival.
// ============================================================================
module http_request_field_tagger_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          PHASE_BYTES  = 470;   // random bytes per idling phase
    localparam int          SETTLE_TICKS = 8;     // idle clocks after the final drain
    localparam int          MAX_REPORTS  = 10;

    // Shapes of generated requests; the broken ones steer the final status.
    typedef enum int {
        REQ_CLEAN,
        REQ_TRUNCATED,
        REQ_CORRUPTED,
        REQ_NOISE,
        REQ_NO_PATH,      // no slash after host/port -> host or port left open
        REQ_ONE_SLASH,    // "/" instead of "//"
        REQ_NO_SPACE,     // no space anywhere -> method never closes
        REQ_NO_BLANK      // final empty line missing
    } t_req_shape;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the parser state, queues predicted words in accept
    // order and compares every returned word against the oldest one.
    // ------------------------------------------------------------------------
    class tag_scoreboard;
        bit                           seen_space;
        hrft_pkg::t_url_phase         phase;
        logic [hrft_pkg::MATCH_W-1:0] blank_match;
        bit                           blank_found;
        bit                           last_cr;
        bit                           in_headers;
        bit                           port80;

        hrft_pkg::t_result            tags_due[$];
        int                           bytes_noted;
        int                           words_checked;
        int                           failures;
        int                           requests_done;
        int                           port80_count;
        int                           status_count[6];

        function new();
            clear_parse();
        endfunction

        function void clear_parse();
            seen_space  = 1'b0;
            phase       = hrft_pkg::PH_SEEK;
            blank_match = hrft_pkg::M_NONE;
            blank_found = 1'b0;
            last_cr     = 1'b0;
            in_headers  = 1'b0;
            port80      = 1'b0;
        endfunction

        function hrft_pkg::t_result predict_tags(logic [hrft_pkg::BYTE_W-1:0] b,
                                                 logic last);
            hrft_pkg::t_result r;
            r          = '0;
            r.byte_out = b;
            r.done_res = last;

            // method: everything before the first space
            r.is_method = !seen_space && (b != hrft_pkg::CH_SP);
            if (b == hrft_pkg::CH_SP)
                seen_space = 1'b1;

            // header tag starts on the byte after the first CR LF
            r.is_header = in_headers;
            if (b == hrft_pkg::CH_LF && last_cr)
                in_headers = 1'b1;
            last_cr = (b == hrft_pkg::CH_CR);

            // CR LF CR LF search
            if (b == hrft_pkg::CH_CR) begin
                blank_match = (blank_match == hrft_pkg::M_CRLF) ? hrft_pkg::M_CRLFC
                                                                : hrft_pkg::M_CR;
            end else if (b == hrft_pkg::CH_LF) begin
                if (blank_match == hrft_pkg::M_CR) begin
                    blank_match = hrft_pkg::M_CRLF;
                end else begin
                    if (blank_match == hrft_pkg::M_CRLFC)
                        blank_found = 1'b1;
                    blank_match = hrft_pkg::M_NONE;
                end
            end else begin
                blank_match = hrft_pkg::M_NONE;
            end

            // URL walk: "//" from the very first byte, then host, port, path
            case (phase)
                hrft_pkg::PH_SEEK: begin
                    if (b == hrft_pkg::CH_SLASH)
                        phase = hrft_pkg::PH_SLASH1;
                end
                hrft_pkg::PH_SLASH1: begin
                    phase = (b == hrft_pkg::CH_SLASH) ? hrft_pkg::PH_HOST
                                                      : hrft_pkg::PH_SEEK;
                end
                hrft_pkg::PH_HOST: begin
                    if (b == hrft_pkg::CH_SLASH) begin
                        port80    = 1'b1;
                        phase     = hrft_pkg::PH_PATH;
                        r.is_path = 1'b1;
                    end else if (b == hrft_pkg::CH_COLON) begin
                        phase = hrft_pkg::PH_PORT;
                    end else begin
                        r.is_host = 1'b1;
                    end
                end
                hrft_pkg::PH_PORT: begin
                    if (b == hrft_pkg::CH_SLASH) begin
                        phase     = hrft_pkg::PH_PATH;
                        r.is_path = 1'b1;
                    end else begin
                        r.is_port = 1'b1;
                    end
                end
                hrft_pkg::PH_PATH: begin
                    if (b == hrft_pkg::CH_SP)
                        phase = hrft_pkg::PH_DONE;
                    else
                        r.is_path = 1'b1;
                end
                default: ;
            endcase

            // status only on the closing byte; first failing check wins
            if (last) begin
                if (!blank_found)
                    r.status = hrft_pkg::ST_NO_END;
                else if (!seen_space)
                    r.status = hrft_pkg::ST_NO_SPACE;
                else if (phase == hrft_pkg::PH_SEEK || phase == hrft_pkg::PH_SLASH1)
                    r.status = hrft_pkg::ST_NO_SLASHES;
                else if (phase == hrft_pkg::PH_HOST)
                    r.status = hrft_pkg::ST_HOST_OPEN;
                else if (phase == hrft_pkg::PH_PORT)
                    r.status = hrft_pkg::ST_PORT_OPEN;
                else
                    r.status = hrft_pkg::ST_OK;
                r.port80_implied = port80;
                clear_parse();
            end
            return r;
        endfunction

        function void note_byte(logic [hrft_pkg::BYTE_W-1:0] b, logic last);
            tags_due.push_back(predict_tags(b, last));
            bytes_noted++;
        endfunction

        function string show(hrft_pkg::t_result r);
            return $sformatf({"byte=%h meth=%b host=%b port=%b path=%b hdr=%b",
                              " done=%b st=%0d p80=%b"},
                             r.byte_out, r.is_method, r.is_host, r.is_port, r.is_path,
                             r.is_header, r.done_res, r.status, r.port80_implied);
        endfunction

        function void report_failure(string msg);
            if (failures < MAX_REPORTS)
                $display("MISMATCH %s", msg);
            failures++;
        endfunction

        function void check_result(hrft_pkg::t_result got);
            hrft_pkg::t_result want;
            bit                bad;
            if (tags_due.size() == 0) begin
                report_failure($sformatf("unexpected word: %s", show(got)));
                return;
            end
            want = tags_due.pop_front();
            bad  = (got.byte_out       !== want.byte_out)
                || (got.is_method      !== want.is_method)
                || (got.is_host        !== want.is_host)
                || (got.is_port        !== want.is_port)
                || (got.is_path        !== want.is_path)
                || (got.is_header      !== want.is_header)
                || (got.done_res       !== want.done_res)
                || (got.status         !== want.status)
                || (got.port80_implied !== want.port80_implied);
            if (bad)
                report_failure($sformatf("word %0d: expected %s | got %s",
                                         words_checked, show(want), show(got)));
            if (want.done_res) begin
                requests_done++;
                status_count[int'(want.status)]++;
                port80_count += want.port80_implied;
            end
            words_checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT hookup. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic [hrft_pkg::BYTE_W-1:0]   i_data_byte = '0;
    logic                          i_last_byte = 1'b0;
    logic                          i_ready     = 1'b0;

    logic                          o_ready;
    logic                          o_valid;
    logic [hrft_pkg::BYTE_W-1:0]   o_byte_out;
    logic                          o_is_method;
    logic                          o_is_host;
    logic                          o_is_port;
    logic                          o_is_path;
    logic                          o_is_header;
    logic                          o_done_res;
    logic [hrft_pkg::STATUS_W-1:0] o_status;
    logic                          o_port80_implied;

    tag_scoreboard                 sb;
    hrft_pkg::t_result             out_word;
    logic [hrft_pkg::BYTE_W-1:0]   req_bytes[$];     // request being assembled
    int                            snd_idle_pct = 23;
    int                            rcv_idle_pct = 86;
    int unsigned                   cycle_count  = 0;

    http_request_field_tagger DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_byte_out       (o_byte_out),
        .o_is_method      (o_is_method),
        .o_is_host        (o_is_host),
        .o_is_port        (o_is_port),
        .o_is_path        (o_is_path),
        .o_is_header      (o_is_header),
        .o_done_res       (o_done_res),
        .o_status         (o_status),
        .o_port80_implied (o_port80_implied)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still due",
                     cycle_count, sb.tags_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: checks the word taken at this edge (pre-edge values), then
    // picks ready for the next cycle. One NBA to i_ready per edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            out_word.byte_out       = o_byte_out;
            out_word.is_method      = o_is_method;
            out_word.is_host        = o_is_host;
            out_word.is_port        = o_is_port;
            out_word.is_path        = o_is_path;
            out_word.is_header      = o_is_header;
            out_word.done_res       = o_done_res;
            out_word.status         = hrft_pkg::t_status'(o_status);
            out_word.port80_implied = o_port80_implied;
            sb.check_result(out_word);
        end
        i_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Random idle cycles first, then hold the word until accepted. Returns at
    // the accepting edge with no NBA yet made in that time step.
    task automatic send_byte(input logic [hrft_pkg::BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_byte(b, last);
    endtask

    task automatic send_request();
        for (int i = 0; i < req_bytes.size(); i++)
            send_byte(req_bytes[i], i == req_bytes.size() - 1);
    endtask

    // Sender holds off until every predicted word has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.tags_due.size() != 0);
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            req_bytes.push_back(s[i]);
    endfunction

    function automatic void add_crlf();
        req_bytes.push_back(hrft_pkg::CH_CR);
        req_bytes.push_back(hrft_pkg::CH_LF);
    endfunction

    function automatic void add_random(string pool, int n);
        for (int i = 0; i < n; i++)
            req_bytes.push_back(pool[$urandom_range(pool.len() - 1)]);
    endfunction

    // Biased toward the bytes the parser reacts to.
    function automatic logic [hrft_pkg::BYTE_W-1:0] noise_byte();
        case ($urandom_range(9))
            0:       return hrft_pkg::CH_CR;
            1:       return hrft_pkg::CH_LF;
            2:       return hrft_pkg::CH_SP;
            3:       return hrft_pkg::CH_SLASH;
            4:       return hrft_pkg::CH_COLON;
            default: return hrft_pkg::BYTE_W'($urandom_range(255));
        endcase
    endfunction

    // Proxy-style request line plus headers, then the chosen damage.
    function automatic void build_request(t_req_shape shape);
        string sp;
        string sep;
        int    keep;
        sp  = (shape == REQ_NO_SPACE) ? "" : " ";
        sep = (shape == REQ_NO_SPACE) ? ":" : ": ";
        req_bytes.delete();

        case ($urandom_range(4))
            0:       add_text("GET");
            1:       add_text("POST");
            2:       add_text("HEAD");
            3:       add_text("CONNECT");
            default: add_random("ABCDEFGHIJKLMNOPQRSTUVWXYZ", $urandom_range(1, 6));
        endcase
        add_text(sp);
        if ($urandom_range(1))
            add_text("http:");
        add_text((shape == REQ_ONE_SLASH) ? "/" : "//");
        add_random("abcdefghijklmnopqrstuvwxyz0123456789.-", $urandom_range(1, 8));
        if ($urandom_range(1)) begin
            add_text(":");
            if ($urandom_range(3) == 0)
                add_text("80");
            else
                add_random("0123456789", $urandom_range(1, 5));
        end
        if (shape != REQ_NO_PATH) begin
            add_text("/");
            add_random("abcdefghijklmnopqrstuvwxyz0123456789/._-?=&:%", $urandom_range(0, 10));
        end
        add_text(sp);
        add_text((shape == REQ_NO_PATH) ? "HTTP1.1" : "HTTP/1.1");
        add_crlf();
        repeat ($urandom_range(2)) begin
            add_random("ABCDEFGHIJKLMNOPQRSTUVWXYZ", $urandom_range(1, 5));
            add_text(sep);
            add_random("abcdefghijklmnopqrstuvwxyz0123456789", $urandom_range(1, 6));
            add_crlf();
        end
        if (shape != REQ_NO_BLANK)
            add_crlf();

        case (shape)
            REQ_TRUNCATED: begin
                keep = $urandom_range(1, req_bytes.size() - 1);
                while (req_bytes.size() > keep)
                    void'(req_bytes.pop_back());
            end
            REQ_CORRUPTED: begin
                repeat ($urandom_range(1, 3))
                    req_bytes[$urandom_range(req_bytes.size() - 1)] = noise_byte();
            end
            REQ_NOISE: begin
                req_bytes.delete();
                repeat ($urandom_range(1, 16))
                    req_bytes.push_back(noise_byte());
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int         stop_at;
        t_req_shape shape;

        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lone zero and all-ones bytes (no blank line), a minimal
        // good request with default port, blank line only (method never
        // closed, header tags after the first CR LF), and "//" at byte zero
        // with the host never closed.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);

        req_bytes.delete();
        add_text(" //a/");
        add_crlf();
        add_crlf();
        send_request();

        req_bytes.delete();
        add_crlf();
        add_crlf();
        send_request();

        req_bytes.delete();
        add_text("//");
        add_crlf();
        add_crlf();
        add_text(" ");
        send_request();

        // Random: three idling phases, drained in between.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct = 23;
                    rcv_idle_pct = 86;
                end
                1: begin
                    snd_idle_pct = 86;
                    rcv_idle_pct = 23;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            stop_at = sb.bytes_noted + PHASE_BYTES;
            while (sb.bytes_noted < stop_at) begin
                if ($urandom_range(99) < 45)
                    shape = REQ_CLEAN;
                else
                    shape = t_req_shape'($urandom_range(1, 7));
                build_request(shape);
                send_request();
            end
            drain_results();
        end

        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("Covered %0d bytes in %0d requests across three idling phases;",
                 sb.bytes_noted, sb.requests_done);
        $display({"  %0d had port 80; final status ok=%0d no_end=%0d no_space=%0d",
                  " no_slashes=%0d host=%0d port=%0d"},
                 sb.port80_count,
                 sb.status_count[hrft_pkg::ST_OK], sb.status_count[hrft_pkg::ST_NO_END],
                 sb.status_count[hrft_pkg::ST_NO_SPACE],
                 sb.status_count[hrft_pkg::ST_NO_SLASHES],
                 sb.status_count[hrft_pkg::ST_HOST_OPEN],
                 sb.status_count[hrft_pkg::ST_PORT_OPEN]);
        if (sb.failures == 0 && sb.tags_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d words never returned",
                     sb.failures, sb.tags_due.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
rtl/hrft_pkg.sv
rtl/hrft_classify.sv
rtl/hrft_result_reg.sv
rtl/http_request_field_tagger.sv
rtl/hrft_checker.sv
bench/http_request_field_tagger_tb.sv
